>>> src/cft_pkg.sv
// Shared types and constants of the Coulomb field line tracer.
// Used by cft_iter and coulomb_field_line_tracer; depends on nothing.
`default_nettype none
package cft_pkg;

   localparam int MAX_CHARGES = 64;
   localparam int ADDR_W      = $clog2(MAX_CHARGES);
   localparam int HELD_W      = $clog2(MAX_CHARGES + 1);

   localparam int COORD_W  = 24;
   localparam int CHARGE_W = 16;
   localparam int FIELD_W  = 64;
   localparam int STEP_W   = 17;
   localparam int ENTRY_W  = 3 * COORD_W + CHARGE_W;

   // Widths inside the shared divide and square-root unit.
   localparam int REM_W   = 50;
   localparam int TRY_W   = REM_W + 2;
   localparam int NUM_W   = 64;
   localparam int STEPS_W = 7;

   localparam logic [STEP_W-1:0] STEP_RESET = 17'd3277;
   localparam logic [33:0]       COULOMB_K  = 34'd8987552000;

   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_QUERY = 2'd1;
   localparam logic [1:0] REQ_TRACE = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;
   localparam logic [1:0] STATUS_ZERO = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADD,
      ST_READ,
      ST_LOAD,
      ST_SQUARE,
      ST_CHARGE_MUL,
      ST_ROOT,
      ST_MAG_DIV,
      ST_UNIT_DIV,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ACCUM,
      ST_NEXT,
      ST_FINISH,
      ST_NORM,
      ST_GSQ,
      ST_NROOT,
      ST_MV_MUL,
      ST_MV_DIV,
      ST_MV_ADD,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic               is_sqrt;
      logic [STEPS_W-1:0] steps;
      logic [REM_W-1:0]   rem0;
      logic [NUM_W-1:0]   num;
      logic [REM_W-1:0]   divisor;
   } iter_cmd_type;

endpackage
`default_nettype wire

>>> src/cft_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
`default_nettype none
module cft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

>>> src/cft_iter.sv
// Shared iterative unit: restoring division one bit per cycle, or integer
// square root two input bits per cycle. Depends on cft_pkg.
`default_nettype none
module cft_iter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire cft_pkg::iter_cmd_type cmd,
   output logic                       busy,
   output logic                       done,
   output logic [cft_pkg::NUM_W-1:0]  quot
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          sqrt_ff, sqrt_in;
   logic [cft_pkg::STEPS_W-1:0]   cnt_ff, cnt_in;
   logic [cft_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [cft_pkg::NUM_W-1:0]     num_ff, num_in;
   logic [cft_pkg::REM_W-1:0]     div_ff, div_in;
   logic [cft_pkg::NUM_W-1:0]     quot_ff, quot_in;
   logic [cft_pkg::TRY_W-1:0]     pad, trial, diff;
   logic                          ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      // The square root brings in two bits and tries (2*root)*2+1; division
      // brings in one bit and tries the divisor. Both share one subtractor.
      if (sqrt_ff) begin
         pad   = {rem_ff, num_ff[cft_pkg::NUM_W-1 -: 2]};
         trial = {quot_ff[cft_pkg::REM_W-1:0], 2'b01};
      end else begin
         pad   = {1'b0, rem_ff, num_ff[cft_pkg::NUM_W-1]};
         trial = {2'b00, div_ff};
      end
      ge   = pad >= trial;
      diff = pad - trial;

      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         sqrt_in = cmd.is_sqrt;
         cnt_in  = cmd.steps;
         rem_in  = cmd.rem0;
         num_in  = cmd.num;
         div_in  = cmd.divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[cft_pkg::REM_W-1:0] : pad[cft_pkg::REM_W-1:0];
         num_in  = sqrt_ff ? {num_ff[cft_pkg::NUM_W-3:0], 2'b00}
                           : {num_ff[cft_pkg::NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[cft_pkg::NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == cft_pkg::STEPS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

>>> src/coulomb_field_line_tracer.sv
// Top level of the Coulomb field line tracer: sequencer, charge table and
// shared multiplier. Depends on cft_pkg, cft_ram and cft_iter.
`default_nettype none
// Takes one item at a time. A field query walks the stored charges in order
// and, for each nonzero charge that is not at the query point, runs a
// 25-step square root, a 63-step division for the magnitude (unless it
// saturates) and three 31-step divisions for the direction, all in one
// shared unit that retires one quotient bit (or one root bit) per cycle,
// plus passes through the shared multiplier. A trace step adds up to 34
// normalizing shifts, a 31-step root and three 18-step divisions. A finished
// result waits in the output register while the next item is taken. There
// is no clearing pass after reset.
module coulomb_field_line_tracer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_type,
   input  wire logic signed [23:0]            req_pos_x,
   input  wire logic signed [23:0]            req_pos_y,
   input  wire logic signed [23:0]            req_pos_z,
   input  wire logic signed [15:0]            req_charge,
   input  wire logic                          req_source_negative,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [63:0]                 rsp_field_x,
   output logic signed [63:0]                 rsp_field_y,
   output logic signed [63:0]                 rsp_field_z,
   output logic signed [23:0]                 rsp_next_x,
   output logic signed [23:0]                 rsp_next_y,
   output logic signed [23:0]                 rsp_next_z,
   output logic [1:0]                         rsp_status,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [16:0]                   csr_step_length
);

   localparam logic signed [63:0] F_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] F_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [23:0] C_MAX = {1'b0, {23{1'b1}}};
   localparam logic signed [23:0] C_MIN = {1'b1, {23{1'b0}}};

   cft_pkg::state_type state_ff, state_in;

   logic [1:0]                    type_ff, type_in;
   logic signed [23:0]            p_ff [3];
   logic signed [23:0]            p_in [3];
   logic signed [15:0]            charge_ff, charge_in;
   logic                          neg_ff, neg_in;
   logic [cft_pkg::HELD_W-1:0]    held_ff, held_in;
   logic [cft_pkg::HELD_W-1:0]    k_ff, k_in;
   logic [1:0]                    a_ff, a_in;
   logic [23:0]                   da_ff [3];
   logic [23:0]                   da_in [3];
   logic [2:0]                    dneg_ff, dneg_in;
   logic                          qneg_ff, qneg_in;
   logic [15:0]                   qmag_ff, qmag_in;
   logic [61:0]                   s_ff, s_in;
   logic [48:0]                   nv_ff, nv_in;
   logic [cft_pkg::REM_W-1:0]     r_ff, r_in;
   logic [62:0]                   mag_ff, mag_in;
   logic [30:0]                   u_ff, u_in;
   logic [93:0]                   prod_ff, prod_in;
   logic signed [63:0]            f_ff [3];
   logic signed [63:0]            f_in [3];
   logic [63:0]                   g_ff [3];
   logic [63:0]                   g_in [3];
   logic signed [23:0]            nx_ff [3];
   logic signed [23:0]            nx_in [3];
   logic                          sat_ff, sat_in;
   logic [1:0]                    status_ff, status_in;
   logic                          pending_ff, pending_in;
   logic [16:0]                   step_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [63:0]            ofield_ff [3];
   logic signed [63:0]            ofield_in [3];
   logic signed [23:0]            onext_ff [3];
   logic signed [23:0]            onext_in [3];
   logic [1:0]                    ostatus_ff, ostatus_in;

   logic [33:0]                   mul_a;
   logic [31:0]                   mul_b;
   logic [65:0]                   mul_p;

   logic                          ram_we;
   logic [cft_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [cft_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

   logic                          iter_start, iter_busy, iter_done;
   cft_pkg::iter_cmd_type         iter_cmd;
   logic [cft_pkg::NUM_W-1:0]     iter_quot;

   logic signed [24:0]            dd [3];
   logic [62:0]                   cmag;
   logic signed [63:0]            ci;
   logic signed [64:0]            fsum;
   logic [63:0]                   gabs [3];
   logic [63:0]                   gmax;
   logic signed [25:0]            mvs, nxw;

   assign mul_p = mul_a * mul_b;

   cft_ram #(
      .WIDTH(cft_pkg::ENTRY_W),
      .DEPTH(cft_pkg::MAX_CHARGES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   cft_iter u_iter (
      .clock(clock),
      .reset(reset),
      .start(iter_start),
      .cmd  (iter_cmd),
      .busy (iter_busy),
      .done (iter_done),
      .quot (iter_quot)
   );

   assign ram_waddr = held_ff[cft_pkg::ADDR_W-1:0];
   assign ram_raddr = k_ff[cft_pkg::ADDR_W-1:0];
   assign ram_wdata = {p_ff[0], p_ff[1], p_ff[2], charge_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cft_pkg::ST_IDLE;
         held_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= cft_pkg::STEP_RESET;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            step_ff <= csr_step_length;
         end
      end
      type_ff    <= type_in;
      p_ff       <= p_in;
      charge_ff  <= charge_in;
      neg_ff     <= neg_in;
      k_ff       <= k_in;
      a_ff       <= a_in;
      da_ff      <= da_in;
      dneg_ff    <= dneg_in;
      qneg_ff    <= qneg_in;
      qmag_ff    <= qmag_in;
      s_ff       <= s_in;
      nv_ff      <= nv_in;
      r_ff       <= r_in;
      mag_ff     <= mag_in;
      u_ff       <= u_in;
      prod_ff    <= prod_in;
      f_ff       <= f_in;
      g_ff       <= g_in;
      nx_ff      <= nx_in;
      sat_ff     <= sat_in;
      status_ff  <= status_in;
      ofield_ff  <= ofield_in;
      onext_ff   <= onext_in;
      ostatus_ff <= ostatus_in;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd[i]   = 25'(p_ff[i]) - 25'(signed'(ram_rdata[cft_pkg::ENTRY_W-1-24*i -: 24]));
         gabs[i] = f_ff[i][63] ? (~f_ff[i] + 64'd1) : f_ff[i];
      end
      gmax = g_ff[0];
      if (g_ff[1] > gmax) begin
         gmax = g_ff[1];
      end
      if (g_ff[2] > gmax) begin
         gmax = g_ff[2];
      end

      cmag = prod_ff[93] ? {63{1'b1}} : prod_ff[92:30];
      ci   = (dneg_ff[a_ff] ^ qneg_ff) ? -signed'({1'b0, cmag}) : signed'({1'b0, cmag});
      fsum = {f_ff[a_ff][63], f_ff[a_ff]} + {ci[63], ci};
      mvs  = signed'({9'd0, u_ff[16:0]});
      if (f_ff[a_ff][63] != neg_ff) begin
         mvs = -mvs;
      end
      nxw  = 26'(p_ff[a_ff]) + mvs;

      state_in   = state_ff;
      type_in    = type_ff;
      p_in       = p_ff;
      charge_in  = charge_ff;
      neg_in     = neg_ff;
      held_in    = held_ff;
      k_in       = k_ff;
      a_in       = a_ff;
      da_in      = da_ff;
      dneg_in    = dneg_ff;
      qneg_in    = qneg_ff;
      qmag_in    = qmag_ff;
      s_in       = s_ff;
      nv_in      = nv_ff;
      r_in       = r_ff;
      mag_in     = mag_ff;
      u_in       = u_ff;
      prod_in    = prod_ff;
      f_in       = f_ff;
      g_in       = g_ff;
      nx_in      = nx_ff;
      sat_in     = sat_ff;
      status_in  = status_ff;
      pending_in = pending_ff;
      ofield_in  = ofield_ff;
      onext_in   = onext_ff;
      ostatus_in = ostatus_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      req_ready  = 1'b0;
      ram_we     = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      iter_start = 1'b0;
      iter_cmd   = '0;

      case (state_ff)
         cft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               type_in   = req_type;
               p_in[0]   = req_pos_x;
               p_in[1]   = req_pos_y;
               p_in[2]   = req_pos_z;
               charge_in = req_charge;
               neg_in    = req_source_negative;
               status_in = cft_pkg::STATUS_OK;
               sat_in    = 1'b0;
               k_in      = '0;
               for (int i = 0; i < 3; i++) begin
                  f_in[i] = '0;
               end
               if (req_type == cft_pkg::REQ_ADD) begin
                  state_in = cft_pkg::ST_ADD;
               end else if (req_type == cft_pkg::REQ_QUERY ||
                            req_type == cft_pkg::REQ_TRACE) begin
                  state_in = cft_pkg::ST_READ;
               end else begin
                  state_in = cft_pkg::ST_RESULT;
               end
            end
         end
         cft_pkg::ST_ADD: begin
            if (held_ff == cft_pkg::HELD_W'(cft_pkg::MAX_CHARGES)) begin
               status_in = cft_pkg::STATUS_FULL;
            end else begin
               ram_we  = 1'b1;
               held_in = held_ff + 1'b1;
            end
            state_in = cft_pkg::ST_RESULT;
         end
         cft_pkg::ST_READ: begin
            state_in = (k_ff == held_ff) ? cft_pkg::ST_FINISH : cft_pkg::ST_LOAD;
         end
         cft_pkg::ST_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               dneg_in[i] = dd[i][24];
               da_in[i]   = dd[i][24] ? 24'(-dd[i]) : dd[i][23:0];
            end
            qneg_in  = ram_rdata[15];
            qmag_in  = ram_rdata[15] ? (~ram_rdata[15:0] + 16'd1) : ram_rdata[15:0];
            s_in     = '0;
            a_in     = '0;
            state_in = cft_pkg::ST_SQUARE;
         end
         cft_pkg::ST_SQUARE: begin
            mul_a = {10'd0, da_ff[a_ff]};
            mul_b = {8'd0, da_ff[a_ff]};
            s_in  = s_ff + {14'd0, mul_p[47:0]};
            if (a_ff == 2'd2) begin
               a_in     = '0;
               state_in = cft_pkg::ST_CHARGE_MUL;
            end else begin
               a_in = a_ff + 1'b1;
            end
         end
         cft_pkg::ST_CHARGE_MUL: begin
            // A charge at the point, or a zero charge, adds nothing.
            if (s_ff == '0 || qmag_ff == '0) begin
               state_in = cft_pkg::ST_NEXT;
            end else begin
               mul_a    = cft_pkg::COULOMB_K;
               mul_b    = {16'd0, qmag_ff};
               nv_in    = mul_p[48:0];
               state_in = cft_pkg::ST_ROOT;
            end
         end
         cft_pkg::ST_ROOT: begin
            iter_cmd.is_sqrt = 1'b1;
            iter_cmd.steps   = 7'd25;
            iter_cmd.num     = {s_ff[49:0], 14'd0};
            if (!pending_ff) begin
               iter_start = 1'b1;
               pending_in = 1'b1;
            end else if (iter_done) begin
               pending_in = 1'b0;
               r_in       = iter_quot[cft_pkg::REM_W-1:0];
               state_in   = cft_pkg::ST_MAG_DIV;
            end
         end
         cft_pkg::ST_MAG_DIV: begin
            // The quotient K*|q|*2^40/S overflows 63 bits exactly when the
            // part of the numerator above bit 63 already reaches S.
            iter_cmd.steps   = 7'd63;
            iter_cmd.rem0    = {24'd0, nv_ff[48:23]};
            iter_cmd.num     = {nv_ff[22:0], 41'd0};
            iter_cmd.divisor = s_ff[49:0];
            a_in             = '0;
            if (!pending_ff) begin
               if ({36'd0, nv_ff[48:23]} >= s_ff) begin
                  mag_in   = {63{1'b1}};
                  sat_in   = 1'b1;
                  state_in = cft_pkg::ST_UNIT_DIV;
               end else begin
                  iter_start = 1'b1;
                  pending_in = 1'b1;
               end
            end else if (iter_done) begin
               pending_in = 1'b0;
               mag_in     = iter_quot[62:0];
               state_in   = cft_pkg::ST_UNIT_DIV;
            end
         end
         cft_pkg::ST_UNIT_DIV: begin
            iter_cmd.steps   = 7'd31;
            iter_cmd.rem0    = {27'd0, da_ff[a_ff][23:1]};
            iter_cmd.num     = {da_ff[a_ff][0], 63'd0};
            iter_cmd.divisor = r_ff;
            if (!pending_ff) begin
               iter_start = 1'b1;
               pending_in = 1'b1;
            end else if (iter_done) begin
               pending_in = 1'b0;
               u_in       = iter_quot[30:0];
               state_in   = cft_pkg::ST_MUL_LO;
            end
         end
         cft_pkg::ST_MUL_LO: begin
            mul_a    = {2'd0, mag_ff[31:0]};
            mul_b    = {1'b0, u_ff};
            prod_in  = {31'd0, mul_p[62:0]};
            state_in = cft_pkg::ST_MUL_HI;
         end
         cft_pkg::ST_MUL_HI: begin
            mul_a    = {3'd0, mag_ff[62:32]};
            mul_b    = {1'b0, u_ff};
            prod_in  = prod_ff + {mul_p[61:0], 32'd0};
            state_in = cft_pkg::ST_ACCUM;
         end
         cft_pkg::ST_ACCUM: begin
            if (prod_ff[93]) begin
               sat_in = 1'b1;
            end
            if (fsum[64] != fsum[63]) begin
               sat_in     = 1'b1;
               f_in[a_ff] = fsum[64] ? F_MIN : F_MAX;
            end else begin
               f_in[a_ff] = fsum[63:0];
            end
            if (a_ff == 2'd2) begin
               state_in = cft_pkg::ST_NEXT;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = cft_pkg::ST_UNIT_DIV;
            end
         end
         cft_pkg::ST_NEXT: begin
            k_in     = k_ff + 1'b1;
            state_in = cft_pkg::ST_READ;
         end
         cft_pkg::ST_FINISH: begin
            if (type_ff == cft_pkg::REQ_QUERY) begin
               status_in = sat_ff ? cft_pkg::STATUS_SAT : cft_pkg::STATUS_OK;
               state_in  = cft_pkg::ST_RESULT;
            end else if (gabs[0] == '0 && gabs[1] == '0 && gabs[2] == '0) begin
               nx_in     = p_ff;
               status_in = cft_pkg::STATUS_ZERO;
               state_in  = cft_pkg::ST_RESULT;
            end else begin
               g_in     = gabs;
               state_in = cft_pkg::ST_NORM;
            end
         end
         cft_pkg::ST_NORM: begin
            // Shift all three together until the largest has exactly 30 bits.
            if (gmax[63:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  g_in[i] = g_ff[i] >> 1;
               end
            end else if (!gmax[29]) begin
               for (int i = 0; i < 3; i++) begin
                  g_in[i] = g_ff[i] << 1;
               end
            end else begin
               a_in     = '0;
               s_in     = '0;
               state_in = cft_pkg::ST_GSQ;
            end
         end
         cft_pkg::ST_GSQ: begin
            mul_a = {4'd0, g_ff[a_ff][29:0]};
            mul_b = {2'd0, g_ff[a_ff][29:0]};
            s_in  = s_ff + mul_p[61:0];
            if (a_ff == 2'd2) begin
               a_in     = '0;
               state_in = cft_pkg::ST_NROOT;
            end else begin
               a_in = a_ff + 1'b1;
            end
         end
         cft_pkg::ST_NROOT: begin
            iter_cmd.is_sqrt = 1'b1;
            iter_cmd.steps   = 7'd31;
            iter_cmd.num     = {s_ff, 2'd0};
            if (!pending_ff) begin
               iter_start = 1'b1;
               pending_in = 1'b1;
            end else if (iter_done) begin
               pending_in = 1'b0;
               r_in       = iter_quot[cft_pkg::REM_W-1:0];
               state_in   = cft_pkg::ST_MV_MUL;
            end
         end
         cft_pkg::ST_MV_MUL: begin
            mul_a    = {4'd0, g_ff[a_ff][29:0]};
            mul_b    = {15'd0, step_ff};
            prod_in  = {47'd0, mul_p[46:0]};
            state_in = cft_pkg::ST_MV_DIV;
         end
         cft_pkg::ST_MV_DIV: begin
            iter_cmd.steps   = 7'd18;
            iter_cmd.rem0    = {21'd0, prod_ff[46:18]};
            iter_cmd.num     = {prod_ff[17:0], 46'd0};
            iter_cmd.divisor = r_ff;
            if (!pending_ff) begin
               iter_start = 1'b1;
               pending_in = 1'b1;
            end else if (iter_done) begin
               pending_in = 1'b0;
               u_in       = iter_quot[30:0];
               state_in   = cft_pkg::ST_MV_ADD;
            end
         end
         cft_pkg::ST_MV_ADD: begin
            if (nxw[25:23] != 3'b000 && nxw[25:23] != 3'b111) begin
               sat_in      = 1'b1;
               nx_in[a_ff] = nxw[25] ? C_MIN : C_MAX;
            end else begin
               nx_in[a_ff] = nxw[23:0];
            end
            if (a_ff == 2'd2) begin
               status_in = (sat_in) ? cft_pkg::STATUS_SAT : cft_pkg::STATUS_OK;
               state_in  = cft_pkg::ST_RESULT;
            end else begin
               a_in     = a_ff + 1'b1;
               state_in = cft_pkg::ST_MV_MUL;
            end
         end
         cft_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               for (int i = 0; i < 3; i++) begin
                  ofield_in[i] = (type_ff == cft_pkg::REQ_QUERY) ? f_ff[i] : '0;
                  onext_in[i]  = (type_ff == cft_pkg::REQ_TRACE) ? nx_ff[i] : '0;
               end
               ostatus_in   = status_ff;
               rsp_valid_in = 1'b1;
               state_in     = cft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cft_pkg::ST_IDLE;
         end
      endcase
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_field_x = ofield_ff[0];
   assign rsp_field_y = ofield_ff[1];
   assign rsp_field_z = ofield_ff[2];
   assign rsp_next_x  = onext_ff[0];
   assign rsp_next_y  = onext_ff[1];
   assign rsp_next_z  = onext_ff[2];
   assign rsp_status  = ostatus_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= cft_pkg::HELD_W'(cft_pkg::MAX_CHARGES))
      else $error("charge count exceeds the table depth");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> held_ff < cft_pkg::HELD_W'(cft_pkg::MAX_CHARGES))
      else $error("table write with the table full");

   a_iter_free: assert property (@(posedge clock) disable iff (reset)
      iter_start |-> !iter_busy && !iter_done)
      else $error("shared unit started while still in use");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cft_pkg::ST_RESULT && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

endmodule
`default_nettype wire

>>> tb/sv/coulomb_field_line_tracer_tb.sv
// Self-checking testbench for coulomb_field_line_tracer: directed table, then random items,
// with a local fixed-point predictor. Depends on cft_pkg and the block itself.
`default_nettype none
module coulomb_field_line_tracer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
   localparam int IDLE_LIMIT = 60000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [23:0] x, y, z;
      logic signed [15:0] q;
      logic               sneg;
      bit                 typed;
      logic signed [63:0] fx, fy, fz;
      logic signed [23:0] nx, ny, nz;
      logic [1:0]         status;
   } field_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [1:0] req_type = cft_pkg::REQ_ADD;
   logic signed [23:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [15:0] req_charge = '0;
   logic req_source_negative = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic signed [63:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic signed [23:0] rsp_next_x, rsp_next_y, rsp_next_z;
   logic [1:0] rsp_status;
   logic csr_valid = 1'b0, csr_ready;
   logic [16:0] csr_step_length = cft_pkg::STEP_RESET;

   coulomb_field_line_tracer dut (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_pos_x, .req_pos_y,
      .req_pos_z, .req_charge, .req_source_negative, .rsp_valid, .rsp_ready,
      .rsp_field_x, .rsp_field_y, .rsp_field_z, .rsp_next_x, .rsp_next_y,
      .rsp_next_z, .rsp_status, .csr_valid, .csr_ready, .csr_step_length
   );

   always #1 clock = ~clock;

   // Predictor copy of the charge table and the step register.
   logic signed [23:0] table_x [cft_pkg::MAX_CHARGES];
   logic signed [23:0] table_y [cft_pkg::MAX_CHARGES];
   logic signed [23:0] table_z [cft_pkg::MAX_CHARGES];
   logic signed [15:0] table_q [cft_pkg::MAX_CHARGES];
   int                 held_count;
   logic [16:0]        step_len;
   logic signed [63:0] field_sum [3];
   bit                 field_sat;

   field_item_type pending_results[$];
   field_item_type directed_rows[$];
   int   mismatches;
   int   idle_cycles;

   function automatic void enqueue_result(field_item_type it);
      pending_results.insert(pending_results.size(), it);
   endfunction

   function automatic void add_row(field_item_type it);
      directed_rows.insert(directed_rows.size(), it);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Superposition of all held charges at one point, saturating.
   function automatic void sum_field(longint p[3]);
      longint d [3];
      logic [63:0] ad [3];
      logic [63:0] s, r, mag, u, qm;
      logic [127:0] quo, pr;
      logic signed [63:0] ci;
      logic signed [64:0] tot;
      for (int a = 0; a < 3; a++) field_sum[a] = 0;
      field_sat = 0;
      for (int k = 0; k < held_count; k++) begin
         d[0] = p[0] - longint'(table_x[k]);
         d[1] = p[1] - longint'(table_y[k]);
         d[2] = p[2] - longint'(table_z[k]);
         s = 0;
         for (int a = 0; a < 3; a++) begin
            ad[a] = d[a] < 0 ? 64'(-d[a]) : 64'(d[a]);
            s = s + ad[a] * ad[a];
         end
         if (s == 0 || table_q[k] == 0) continue;
         r = int_sqrt(s);
         qm = table_q[k] < 0 ? 64'(-longint'(table_q[k])) : 64'(table_q[k]);
         quo = ({64'd0, 64'(cft_pkg::COULOMB_K) * qm} << 40) / {64'd0, s};
         if (quo > {64'd0, I64_MAX}) begin
            mag = I64_MAX;
            field_sat = 1;
         end else begin
            mag = quo[63:0];
         end
         for (int a = 0; a < 3; a++) begin
            u = (ad[a] << 30) / r;
            pr = ({64'd0, mag} * {64'd0, u}) >> 30;
            if (pr > {64'd0, I64_MAX}) begin
               pr = {64'd0, I64_MAX};
               field_sat = 1;
            end
            ci = pr[63:0];
            if ((d[a] < 0) != (table_q[k] < 0)) ci = -ci;
            tot = {field_sum[a][63], field_sum[a]} + {ci[63], ci};
            if (tot[64] != tot[63]) begin
               field_sum[a] = tot[64] ? I64_MIN : I64_MAX;
               field_sat = 1;
            end else begin
               field_sum[a] = tot[63:0];
            end
         end
      end
   endfunction

   // Expected response of one accepted item; updates the table on an add.
   function automatic field_item_type predict_response(field_item_type it);
      field_item_type e;
      longint p [3];
      logic [63:0] g [3];
      logic [63:0] mx, acc, n;
      longint mv, nxt;
      logic signed [23:0] outp [3];
      int len;
      e = it;
      e.fx = 0; e.fy = 0; e.fz = 0;
      e.nx = 0; e.ny = 0; e.nz = 0;
      e.status = cft_pkg::STATUS_OK;
      p[0] = it.x; p[1] = it.y; p[2] = it.z;
      case (it.kind)
         cft_pkg::REQ_ADD: begin
            if (held_count >= cft_pkg::MAX_CHARGES) begin
               e.status = cft_pkg::STATUS_FULL;
            end else begin
               table_x[held_count] = it.x;
               table_y[held_count] = it.y;
               table_z[held_count] = it.z;
               table_q[held_count] = it.q;
               held_count++;
            end
         end
         cft_pkg::REQ_QUERY: begin
            sum_field(p);
            e.fx = field_sum[0]; e.fy = field_sum[1]; e.fz = field_sum[2];
            e.status = field_sat ? cft_pkg::STATUS_SAT : cft_pkg::STATUS_OK;
         end
         cft_pkg::REQ_TRACE: begin
            sum_field(p);
            mx = 0;
            for (int a = 0; a < 3; a++) begin
               g[a] = field_sum[a][63] ? -field_sum[a] : field_sum[a];
               if (g[a] > mx) mx = g[a];
            end
            if (mx == 0) begin
               e.nx = it.x; e.ny = it.y; e.nz = it.z;
               e.status = cft_pkg::STATUS_ZERO;
            end else begin
               len = 0;
               while (len < 64 && (mx >> len) != 0) len++;
               acc = 0;
               for (int a = 0; a < 3; a++) begin
                  g[a] = len > 30 ? g[a] >> (len - 30) : g[a] << (30 - len);
                  acc = acc + g[a] * g[a];
               end
               n = int_sqrt(acc);
               for (int a = 0; a < 3; a++) begin
                  mv = longint'((g[a] * 64'(step_len)) / n);
                  if ((field_sum[a] < 0) != it.sneg) mv = -mv;
                  nxt = p[a] + mv;
                  if (nxt > 8388607) begin
                     nxt = 8388607;
                     field_sat = 1;
                  end
                  if (nxt < -8388608) begin
                     nxt = -8388608;
                     field_sat = 1;
                  end
                  outp[a] = nxt[23:0];
               end
               e.nx = outp[0]; e.ny = outp[1]; e.nz = outp[2];
               e.status = field_sat ? cft_pkg::STATUS_SAT : cft_pkg::STATUS_OK;
            end
         end
         default: ;
      endcase
      return e;
   endfunction

   function automatic field_item_type make_item(logic [1:0] kind, int x, int y, int z,
                                                int q, bit sneg);
      field_item_type it;
      it = '{default: 0};
      it.kind = kind;
      it.x = 24'(x); it.y = 24'(y); it.z = 24'(z);
      it.q = 16'(q); it.sneg = sneg;
      return it;
   endfunction

   function automatic logic signed [23:0] pick_coord(int mode, logic signed [23:0] near);
      case (mode)
         0: return 24'($urandom);
         1: return near + 24'($urandom_range(0, 512)) - 24'sd256;
         2: return near;
         default: return $urandom_range(0, 1) ? 24'sd8388607 - 24'($urandom_range(0, 4096))
                                            : -24'sd8388608 + 24'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic field_item_type random_item(int add_pct);
      field_item_type it;
      int roll, mode, k;
      it = '{default: 0};
      roll = $urandom_range(0, 99);
      if (roll < add_pct) it.kind = cft_pkg::REQ_ADD;
      else if (roll < add_pct + (100 - add_pct) / 2) it.kind = cft_pkg::REQ_QUERY;
      else if (roll < 96) it.kind = cft_pkg::REQ_TRACE;
      else it.kind = REQ_UNUSED;
      mode = $urandom_range(0, 5);
      if (held_count == 0 && (mode == 1 || mode == 2)) mode = 0;
      if (mode > 3) mode = 1;
      k = held_count == 0 ? 0 : $urandom_range(0, held_count - 1);
      it.x = pick_coord(mode, held_count == 0 ? 24'sd0 : table_x[k]);
      it.y = pick_coord(mode, held_count == 0 ? 24'sd0 : table_y[k]);
      it.z = pick_coord(mode, held_count == 0 ? 24'sd0 : table_z[k]);
      it.q = $urandom_range(0, 7) == 0 ? 16'sd0 : 16'($urandom);
      it.sneg = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Sender with bursts and gaps. Called at a falling edge, returns at one.
   int burst_left = 0;
   task automatic send_item(field_item_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_type <= it.kind;
      req_pos_x <= it.x;
      req_pos_y <= it.y;
      req_pos_z <= it.z;
      req_charge <= it.q;
      req_source_negative <= it.sneg;
      do @(posedge clock); while (!req_ready);
      if (it.typed) begin
         void'(predict_response(it));
         enqueue_result(it);
      end else begin
         enqueue_result(predict_response(it));
      end
      @(negedge clock);
   endtask

   // The block is idle once every result is back; then the register is written.
   task automatic write_step(logic [16:0] value);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_step_length <= value;
      do @(posedge clock); while (!csr_ready);
      step_len = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count, int add_pct);
      repeat (count) send_item(random_item(add_pct));
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      field_item_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected item", 64'd1, 64'd0);
         end else begin
            e = pending_results.pop_front();
            report("field_x", rsp_field_x, e.fx);
            report("field_y", rsp_field_y, e.fy);
            report("field_z", rsp_field_z, e.fz);
            report("next_x", 64'(rsp_next_x), 64'(e.nx));
            report("next_y", 64'(rsp_next_y), 64'(e.ny));
            report("next_z", 64'(rsp_next_z), 64'(e.nz));
            report("status", 64'(rsp_status), 64'(e.status));
         end
      end
   end

   // Receiver stalls follow a random mode, picked anew as ready_count advances.
   int ready_mode = 0, ready_count = 0;
   always @(negedge clock) begin
      ready_count++;
      if (ready_count % 50 == 0) ready_mode = $urandom_range(0, 2);
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= (ready_count % 8) == 0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      field_item_type row;
      mismatches = 0;
      idle_cycles = 0;
      held_count = 0;
      step_len = cft_pkg::STEP_RESET;

      // Typed rows: empty table, unused request type.
      row = make_item(cft_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
      row.typed = 1;
      add_row(row);
      row = make_item(cft_pkg::REQ_TRACE, 8388607, 8388607, 8388607, 0, 0);
      row.typed = 1;
      row.nx = 24'(8388607); row.ny = 24'(8388607); row.nz = 24'(8388607);
      row.status = cft_pkg::STATUS_ZERO;
      add_row(row);
      row = make_item(cft_pkg::REQ_TRACE, -8388608, -8388608, -8388608, -1, 1);
      row.typed = 1;
      row.nx = 24'(-8388608); row.ny = 24'(-8388608); row.nz = 24'(-8388608);
      row.status = cft_pkg::STATUS_ZERO;
      add_row(row);
      row = make_item(REQ_UNUSED, -1, -1, -1, -1, 1);
      row.typed = 1;
      add_row(row);
      // Predicted rows: extreme charges, a zero charge, a charge at the point, saturation.
      add_row(make_item(cft_pkg::REQ_ADD, 0, 0, 0, 32767, 0));
      add_row(make_item(cft_pkg::REQ_ADD, 8388607, 8388607, 8388607, -32768, 0));
      add_row(make_item(cft_pkg::REQ_ADD, -8388608, -8388608, -8388608, 0, 0));
      add_row(make_item(cft_pkg::REQ_ADD, 65536, -65536, 131072, 256, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, 0, 0, 0, 0, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, 1, 0, 0, 0, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, 8388607, 8388607, 8388606, 0, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, -8388608, -8388608, -8388608, 0, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, 3000000, -2000000, 500000, 0, 0));
      add_row(make_item(cft_pkg::REQ_TRACE, 65536, 0, 0, 0, 0));
      add_row(make_item(cft_pkg::REQ_TRACE, 65536, 0, 0, 0, 1));
      add_row(make_item(cft_pkg::REQ_TRACE, 8388607, 8388607, 8388600, 0, 1));
      add_row(make_item(cft_pkg::REQ_TRACE, 0, 0, 0, 0, 0));
      add_row(make_item(cft_pkg::REQ_TRACE, -8388608, 8388607, 0, 0, 1));
      add_row(make_item(cft_pkg::REQ_ADD, -4000000, 4000000, 0, -1, 0));
      add_row(make_item(cft_pkg::REQ_QUERY, -4000000, 4000001, 0, 0, 0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      write_step(17'd65536);
      run_random(25, 25);
      write_step(17'd0);
      run_random(25, 30);
      write_step(17'($urandom_range(1, 65535)));
      // Mostly adds here, so the table fills and later adds are dropped.
      run_random(70, 75);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
